/* sv/rjb_pkg.sv */
// Shared types, codes and defaults of the RTP reorder jitter buffer.
package rjb_pkg;

  localparam int RJB_WINDOW = 32;

  localparam int SEQ_W  = 16;
  localparam int TAG_W  = 16;
  localparam int EXT_W  = 40;
  localparam int TIME_W = 32;
  localparam int REG_W  = 16;
  localparam int IDX_W  = 8;
  localparam int STAT_W = 2;

  // One stored slot: tag, extended sequence and arrival time.
  localparam int SLOT_W   = TAG_W + EXT_W + TIME_W;
  localparam int TIME_LSB = 0;
  localparam int EXT_LSB  = TIME_W;
  localparam int TAG_LSB  = TIME_W + EXT_W;

  localparam logic [REG_W-1:0] DEF_TIMEOUT     = 16'd100;
  localparam logic [REG_W-1:0] DEF_REPORT_INT  = 16'd500;
  localparam logic [REG_W-1:0] DEF_MAX_DROPOUT = 16'd3000;
  localparam logic [REG_W-1:0] DEF_MAX_MISORD  = 16'd100;

  localparam logic [SEQ_W:0] NO_SEQ = 17'd65537;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [STAT_W-1:0] ST_RELEASED = 2'd0;
  localparam logic [STAT_W-1:0] ST_REPORTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 2'd2;

  localparam logic [IDX_W-1:0] REG_TIMEOUT     = 8'd0;
  localparam logic [IDX_W-1:0] REG_REPORT_INT  = 8'd1;
  localparam logic [IDX_W-1:0] REG_MAX_DROPOUT = 8'd2;
  localparam logic [IDX_W-1:0] REG_MAX_MISORD  = 8'd3;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [EXT_W-1:0]  ext;
    logic [STAT_W-1:0] status;
  } result_t;

endpackage

/* sv/rjb_if.sv */
// Channel interfaces of the RTP reorder jitter buffer.
interface rjb_in_if import rjb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [SEQ_W-1:0]  seq_num;
  logic [TAG_W-1:0]  packet_tag;
  logic [TIME_W-1:0] now_ms;
  modport source (output valid, operation, seq_num, packet_tag, now_ms, input ready);
  modport sink   (input valid, operation, seq_num, packet_tag, now_ms, output ready);
endinterface

interface rjb_out_if import rjb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TAG_W-1:0]  out_tag;
  logic [EXT_W-1:0]  out_ext_seq;
  logic [STAT_W-1:0] status;
  logic              last;
  modport source (output valid, out_tag, out_ext_seq, status, last, input ready);
  modport sink   (input valid, out_tag, out_ext_seq, status, last, output ready);
endinterface

interface rjb_cfg_if import rjb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [REG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/rtp_reorder_jitter_buffer.sv */
// Top level of the RTP reorder jitter buffer: sequence extension, slot store and release.
//
// Each input item is either a packet arrival or a timer tick, and it produces
// zero or more result items, the final one flagged with last. The block works on
// one item at a time and holds in_if.ready low until every result of that item
// has been handed to the output register. All slot lookups go through a single
// read port of the slot RAM, one slot per cycle, and one comparator that keeps
// the best candidate over a lookup pass of every slot. An arrival that is
// released in order goes through S_SEQ, S_EXT and S_CLASS and then takes one
// pass for every packet drained behind it plus one. An early arrival costs one
// pass to look for a duplicate and then the timeout scan, which takes one pass
// for every held packet plus one; a tick runs the timeout scan alone. A result
// that the sink does not take stalls the sequencer once the output register and
// the one-item holding stage are both full. The holding stage lets the last flag
// be set on the final result. Sequence numbers are extended following RFC 3550,
// with a re-sync after two consecutive packets beyond the dropout limit.
// Configuration writes are always accepted and must come only while the block
// is idle.
module rtp_reorder_jitter_buffer import rjb_pkg::*; #(
  parameter int WINDOW = RJB_WINDOW
) (
  input  logic      clk,
  input  logic      rst_n,
  rjb_in_if.sink    in_if,
  rjb_out_if.source out_if,
  rjb_cfg_if.sink   cfg_if
);
  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(WINDOW);

  typedef enum logic [3:0] {
    S_IDLE, S_SEQ, S_EXT, S_CLASS, S_SRCH, S_INSERT, S_DRAIN, S_SCAN, S_FLUSH
  } state_t;

  // What the current lookup pass is looking for.
  typedef enum logic [1:0] {M_MATCH, M_MIN, M_SCAN} mode_t;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;

  // Configuration registers.
  logic [REG_W-1:0] tmo_r, tmo_nxt, rint_r, rint_nxt;
  logic [REG_W-1:0] mdrop_r, mdrop_nxt, mmis_r, mmis_nxt;

  // Sequence-extension state.
  logic              started_r, started_nxt;
  logic [SEQ_W-1:0]  hs_r, hs_nxt;
  logic [SEQ_W:0]    suspect_r, suspect_nxt;
  logic [EXT_W-1:0]  wrap_r, wrap_nxt;
  logic [EXT_W-1:0]  lrs_r, lrs_nxt;
  logic [TIME_W-1:0] last_rep_r, last_rep_nxt;
  logic [WINDOW-1:0] valid_r, valid_nxt;

  // The item being worked on.
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [EXT_W-1:0]  ext_r, ext_nxt;

  // Lookup pass.
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              rd_v_r, rd_v_nxt;
  logic [AW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              found_r, found_nxt;
  logic [AW-1:0]     best_idx_r, best_idx_nxt;
  logic [EXT_W-1:0]  best_ext_r, best_ext_nxt;
  logic [TAG_W-1:0]  best_tag_r, best_tag_nxt;
  logic [TIME_W-1:0] best_time_r, best_time_nxt;
  logic              lo_en_r, lo_en_nxt;
  logic [EXT_W-1:0]  cursor_r, cursor_nxt;

  // Holding stage and output register.
  logic    hold_v_r, hold_v_nxt;
  result_t hold_r, hold_nxt;
  logic    out_v_r, out_v_nxt;
  result_t out_r, out_nxt;
  logic    out_last_r, out_last_nxt;

  // Slot RAM.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [SLOT_W-1:0] ram_wdata, ram_rdata;
  logic [AW-1:0]     ram_raddr;

  logic [EXT_W-1:0]  rd_ext;
  logic [TAG_W-1:0]  rd_tag;
  logic [TIME_W-1:0] rd_time;
  logic              rd_hit;

  logic [EXT_W-1:0]  lrs_inc;
  logic              rep_due;
  logic              out_free;
  logic              can_emit;
  logic              emit_en;
  result_t           emit_res;
  logic              free_any;
  logic [AW-1:0]     free_idx;
  logic [SEQ_W-1:0]  udelta;
  logic              aged;
  logic              next_up;
  logic [AW-1:0]     ins_idx;

  rjb_ram #(.WIDTH(SLOT_W), .DEPTH(WINDOW)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ext  = ram_rdata[EXT_LSB +: EXT_W];
  assign rd_tag  = ram_rdata[TAG_LSB +: TAG_W];
  assign rd_time = ram_rdata[TIME_LSB +: TIME_W];
  assign ram_raddr = cnt_r[AW-1:0];

  assign lrs_inc  = lrs_r + EXT_W'(1);
  assign rep_due  = (now_r - last_rep_r) > {{(TIME_W-REG_W){1'b0}}, rint_r};
  assign out_free = !out_v_r || out_if.ready;
  assign can_emit = !hold_v_r || out_free;
  assign udelta   = seq_r - hs_r;
  assign aged     = (now_r - best_time_r) > {{(TIME_W-REG_W){1'b0}}, tmo_r};
  assign next_up  = best_ext_r == lrs_inc;

  // Lowest free slot.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = WINDOW - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  // Candidate test of the slot whose data the RAM presents this cycle.
  always_comb begin
    rd_hit = 1'b0;
    if (rd_v_r && valid_r[rd_idx_r]) begin
      unique case (mode_r)
        M_MATCH: rd_hit = !found_r && (rd_ext == ext_r);
        M_MIN, M_SCAN: rd_hit = (!lo_en_r || rd_ext > cursor_r) &&
                                (!found_r || rd_ext < best_ext_r);
        default: rd_hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    tmo_nxt       = tmo_r;
    rint_nxt      = rint_r;
    mdrop_nxt     = mdrop_r;
    mmis_nxt      = mmis_r;
    started_nxt   = started_r;
    hs_nxt        = hs_r;
    suspect_nxt   = suspect_r;
    wrap_nxt      = wrap_r;
    lrs_nxt       = lrs_r;
    last_rep_nxt  = last_rep_r;
    valid_nxt     = valid_r;
    seq_nxt       = seq_r;
    tag_nxt       = tag_r;
    now_nxt       = now_r;
    ext_nxt       = ext_r;
    cnt_nxt       = cnt_r;
    rd_v_nxt      = 1'b0;
    rd_idx_nxt    = cnt_r[AW-1:0];
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_ext_nxt  = best_ext_r;
    best_tag_nxt  = best_tag_r;
    best_time_nxt = best_time_r;
    lo_en_nxt     = lo_en_r;
    cursor_nxt    = cursor_r;
    emit_en       = 1'b0;
    emit_res      = '{tag: tag_r, ext: ext_r, status: ST_RELEASED};
    ram_we        = 1'b0;
    ram_waddr     = free_idx;
    ram_wdata     = {tag_r, ext_r, now_r};
    ins_idx       = free_idx;

    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_TIMEOUT:     tmo_nxt   = cfg_if.data;
        REG_REPORT_INT:  rint_nxt  = cfg_if.data;
        REG_MAX_DROPOUT: mdrop_nxt = cfg_if.data;
        REG_MAX_MISORD:  mmis_nxt  = cfg_if.data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          seq_nxt = in_if.seq_num;
          tag_nxt = in_if.packet_tag;
          now_nxt = in_if.now_ms;
          if (in_if.operation == OP_TICK) begin
            state_nxt = S_SRCH;
            mode_nxt  = M_SCAN;
            lo_en_nxt = 1'b0;
            found_nxt = 1'b0;
            cnt_nxt   = '0;
          end else begin
            state_nxt = S_SEQ;
          end
        end
      end

      S_SEQ: begin
        if (!started_r || (udelta >= mdrop_r &&
            {1'b0, udelta} <= (17'h10000 - {1'b0, mmis_r}) &&
            {1'b0, seq_r} == suspect_r)) begin
          // First packet, or the second of two consecutive after a jump.
          if (can_emit) begin
            emit_en         = 1'b1;
            emit_res.ext    = {{(EXT_W-SEQ_W){1'b0}}, seq_r};
            emit_res.status = rep_due ? ST_REPORTED : ST_RELEASED;
            if (rep_due) begin
              last_rep_nxt = now_r;
            end
            started_nxt = !started_r;
            hs_nxt      = seq_r;
            suspect_nxt = NO_SEQ;
            wrap_nxt    = '0;
            lrs_nxt     = {{(EXT_W-SEQ_W){1'b0}}, seq_r};
            state_nxt   = S_FLUSH;
          end
        end else if (udelta < mdrop_r) begin
          if (seq_r < hs_r) begin
            wrap_nxt = wrap_r + (EXT_W'(1) << SEQ_W);
          end
          hs_nxt    = seq_r;
          state_nxt = S_EXT;
        end else if ({1'b0, udelta} <= (17'h10000 - {1'b0, mmis_r})) begin
          // Large jump: arm the suspect number, no result.
          suspect_nxt = {1'b0, seq_r + SEQ_W'(1)};
          state_nxt   = S_FLUSH;
        end else begin
          state_nxt = S_EXT;
        end
      end

      S_EXT: begin
        ext_nxt   = wrap_r + {{(EXT_W-SEQ_W){1'b0}}, seq_r};
        state_nxt = S_CLASS;
      end

      S_CLASS: begin
        if (ext_r == lrs_inc) begin
          if (can_emit) begin
            emit_en   = 1'b1;
            lrs_nxt   = ext_r;
            state_nxt = S_SRCH;
            mode_nxt  = M_MIN;
            lo_en_nxt = 1'b0;
            found_nxt = 1'b0;
            cnt_nxt   = '0;
          end
        end else if (ext_r <= lrs_r) begin
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_SRCH;
          mode_nxt  = M_MATCH;
          found_nxt = 1'b0;
          cnt_nxt   = '0;
        end
      end

      S_SRCH: begin
        if (cnt_r != LAST_CNT) begin
          rd_v_nxt = 1'b1;
          cnt_nxt  = cnt_r + CW'(1);
        end
        if (rd_hit) begin
          found_nxt     = 1'b1;
          best_idx_nxt  = rd_idx_r;
          best_ext_nxt  = rd_ext;
          best_tag_nxt  = rd_tag;
          best_time_nxt = rd_time;
        end
        if (cnt_r == LAST_CNT) begin
          unique case (mode_r)
            M_MATCH: state_nxt = S_INSERT;
            M_MIN:   state_nxt = S_DRAIN;
            M_SCAN:  state_nxt = S_SCAN;
            default: state_nxt = S_FLUSH;
          endcase
        end
      end

      S_INSERT: begin
        ins_idx   = found_r ? best_idx_r : free_idx;
        ram_waddr = ins_idx;
        if (found_r || free_any) begin
          ram_we             = 1'b1;
          valid_nxt[ins_idx] = 1'b1;
          state_nxt          = S_SRCH;
        end else if (can_emit) begin
          emit_en         = 1'b1;
          emit_res.status = ST_DROPPED;
          state_nxt       = S_SRCH;
        end
        if (state_nxt == S_SRCH) begin
          mode_nxt  = M_SCAN;
          lo_en_nxt = 1'b0;
          found_nxt = 1'b0;
          cnt_nxt   = '0;
        end
      end

      S_DRAIN: begin
        if (found_r && next_up) begin
          if (can_emit) begin
            emit_en   = 1'b1;
            emit_res  = '{tag: best_tag_r, ext: best_ext_r, status: ST_RELEASED};
            valid_nxt[best_idx_r] = 1'b0;
            lrs_nxt   = best_ext_r;
            state_nxt = S_SRCH;
            found_nxt = 1'b0;
            cnt_nxt   = '0;
          end
        end else begin
          state_nxt = S_FLUSH;
        end
      end

      S_SCAN: begin
        if (!found_r) begin
          state_nxt = S_FLUSH;
        end else if (!(aged || next_up) || can_emit) begin
          if (aged || next_up) begin
            emit_en  = 1'b1;
            emit_res = '{tag: best_tag_r, ext: best_ext_r, status: ST_RELEASED};
            if (aged && rep_due) begin
              emit_res.status = ST_REPORTED;
              last_rep_nxt    = now_r;
            end
            valid_nxt[best_idx_r] = 1'b0;
            lrs_nxt = best_ext_r;
          end
          cursor_nxt = best_ext_r;
          lo_en_nxt  = 1'b1;
          found_nxt  = 1'b0;
          cnt_nxt    = '0;
          state_nxt  = S_SRCH;
        end
      end

      S_FLUSH: begin
        if (!hold_v_r || out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Result path: a new result pushes the held one out with last cleared, and the
  // flush at the end of an item sends the held one with last set.
  always_comb begin
    out_v_nxt    = out_v_r && !out_if.ready;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    hold_v_nxt   = hold_v_r;
    hold_nxt     = hold_r;
    if (emit_en) begin
      if (hold_v_r) begin
        out_v_nxt    = 1'b1;
        out_nxt      = hold_r;
        out_last_nxt = 1'b0;
      end
      hold_v_nxt = 1'b1;
      hold_nxt   = emit_res;
    end else if (state_r == S_FLUSH && hold_v_r && out_free) begin
      out_v_nxt    = 1'b1;
      out_nxt      = hold_r;
      out_last_nxt = 1'b1;
      hold_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    seq_r       <= seq_nxt;
    tag_r       <= tag_nxt;
    now_r       <= now_nxt;
    ext_r       <= ext_nxt;
    rd_idx_r    <= rd_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_ext_r  <= best_ext_nxt;
    best_tag_r  <= best_tag_nxt;
    best_time_r <= best_time_nxt;
    cursor_r    <= cursor_nxt;
    hold_r      <= hold_nxt;
    out_r       <= out_nxt;
    out_last_r  <= out_last_nxt;
    if (!rst_n) begin
      state_r    <= S_IDLE;
      mode_r     <= M_MATCH;
      tmo_r      <= DEF_TIMEOUT;
      rint_r     <= DEF_REPORT_INT;
      mdrop_r    <= DEF_MAX_DROPOUT;
      mmis_r     <= DEF_MAX_MISORD;
      started_r  <= 1'b0;
      hs_r       <= '0;
      suspect_r  <= NO_SEQ;
      wrap_r     <= '0;
      lrs_r      <= '0;
      last_rep_r <= '0;
      valid_r    <= '0;
      cnt_r      <= '0;
      rd_v_r     <= 1'b0;
      found_r    <= 1'b0;
      lo_en_r    <= 1'b0;
      hold_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      mode_r     <= mode_nxt;
      tmo_r      <= tmo_nxt;
      rint_r     <= rint_nxt;
      mdrop_r    <= mdrop_nxt;
      mmis_r     <= mmis_nxt;
      started_r  <= started_nxt;
      hs_r       <= hs_nxt;
      suspect_r  <= suspect_nxt;
      wrap_r     <= wrap_nxt;
      lrs_r      <= lrs_nxt;
      last_rep_r <= last_rep_nxt;
      valid_r    <= valid_nxt;
      cnt_r      <= cnt_nxt;
      rd_v_r     <= rd_v_nxt;
      found_r    <= found_nxt;
      lo_en_r    <= lo_en_nxt;
      hold_v_r   <= hold_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  assign in_if.ready        = (state_r == S_IDLE);
  assign cfg_if.ready       = 1'b1;
  assign out_if.valid       = out_v_r;
  assign out_if.out_tag     = out_r.tag;
  assign out_if.out_ext_seq = out_r.ext;
  assign out_if.status      = out_r.status;
  assign out_if.last        = out_last_r;
endmodule

/* sv/rjb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rjb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/rjb_checker.sv */
// Port-level assertions of the RTP reorder jitter buffer and their binding.
module rjb_port_checker import rjb_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [TAG_W-1:0]  out_tag,
  input logic [EXT_W-1:0]  out_ext_seq,
  input logic [STAT_W-1:0] out_status,
  input logic              cfg_ready
);
  // One item at a time: the block is busy right after taking an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  // No result can appear in the cycle right after an item is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared without sequencing");

  // Only the three defined status codes leave the block.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_RELEASED || out_status == ST_REPORTED ||
                   out_status == ST_DROPPED))
    else $error("undefined status code");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tag) &&
                                $stable(out_ext_seq) && $stable(out_status))
    else $error("stalled result changed");

  // Configuration writes are never refused.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");
endmodule

bind rtp_reorder_jitter_buffer rjb_port_checker u_rjb_port_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_tag     (out_if.out_tag),
  .out_ext_seq (out_if.out_ext_seq),
  .out_status  (out_if.status),
  .cfg_ready   (cfg_if.ready)
);

/* dv/rjb_checker.sv */
`timescale 1ns / 1ps
// Checker that predicts the jitter buffer's results and compares them with the output channel.
module rjb_checker import rjb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  rjb_in_if    in_if,
  rjb_out_if   out_if,
  rjb_cfg_if   cfg_if,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    logic [TAG_W-1:0]  tag;
    logic [EXT_W-1:0]  ext;
    logic [STAT_W-1:0] status;
    logic              last;
  } release_t;

  localparam logic [EXT_W-1:0] EXT_ONE = 40'd1;

  logic [31:0] timeout_ms, report_int, drop_limit, misorder_limit;
  logic              started;
  logic [15:0]       highest_seq;
  logic [16:0]       suspect_seq;
  logic [EXT_W-1:0]  wrap_offset, last_released;
  logic [31:0]       last_report;
  logic              held_valid [RJB_WINDOW];
  logic [TAG_W-1:0]  held_tag   [RJB_WINDOW];
  logic [EXT_W-1:0]  held_ext   [RJB_WINDOW];
  logic [31:0]       held_time  [RJB_WINDOW];

  release_t expected_releases [$];
  release_t step_out [$];

  function automatic logic [1:0] loss_report(input logic [31:0] now);
    if (32'(now - last_report) > report_int) begin
      last_report = now;
      return ST_REPORTED;
    end
    return ST_RELEASED;
  endfunction

  function automatic void push_release(input logic [15:0] tag, input logic [EXT_W-1:0] ext,
                                       input logic [1:0] st);
    release_t r;
    last_released = ext;
    r.tag = tag; r.ext = ext; r.status = st; r.last = 1'b0;
    step_out.push_back(r);
  endfunction

  // Releases held packets in ascending extended order: timed-out ones with a
  // report attempt, and the next in line plainly.
  function automatic void timeout_sweep(input logic [31:0] now);
    int order [$];
    int j;
    for (int i = 0; i < RJB_WINDOW; i++)
      if (held_valid[i]) begin
        j = 0;
        while (j < order.size() && held_ext[order[j]] <= held_ext[i]) j++;
        order.insert(j, i);
      end
    foreach (order[k]) begin
      if (32'(now - held_time[order[k]]) > timeout_ms) begin
        held_valid[order[k]] = 1'b0;
        push_release(held_tag[order[k]], held_ext[order[k]], ST_RELEASED);
        step_out[$].status = loss_report(now);
      end else if (held_ext[order[k]] == last_released + EXT_ONE) begin
        held_valid[order[k]] = 1'b0;
        push_release(held_tag[order[k]], held_ext[order[k]], ST_RELEASED);
      end
    end
  endfunction

  function automatic void predict_item(input logic op, input logic [15:0] seq,
                                       input logic [15:0] tag, input logic [31:0] now);
    logic [15:0] udelta;
    logic [EXT_W-1:0] ext;
    logic [EXT_W-1:0] keep_release;
    int s, best;
    step_out.delete();
    if (op == OP_TICK) begin
      timeout_sweep(now);
    end else if (!started) begin
      started = 1'b1;
      highest_seq = seq; suspect_seq = NO_SEQ; wrap_offset = '0;
      push_release(tag, EXT_W'(seq), loss_report(now));
    end else begin
      udelta = seq - highest_seq;
      if (32'(udelta) < drop_limit) begin
        if (seq < highest_seq) wrap_offset = wrap_offset + 40'd65536;
        highest_seq = seq;
      end else if (32'(udelta) <= 32'd65536 - misorder_limit) begin
        if (17'(seq) == suspect_seq) begin
          highest_seq = seq; suspect_seq = NO_SEQ; wrap_offset = '0;
          started = 1'b0;
          push_release(tag, EXT_W'(seq), loss_report(now));
        end else begin
          suspect_seq = 17'(seq) + 17'd1;
          suspect_seq[16] = 1'b0;
        end
        if (step_out.size() > 0) step_out[$].last = 1'b1;
        foreach (step_out[k]) expected_releases.push_back(step_out[k]);
        return;
      end
      ext = wrap_offset + EXT_W'(seq);
      if (ext == last_released + EXT_ONE) begin
        push_release(tag, ext, ST_RELEASED);
        forever begin
          best = -1;
          for (int i = 0; i < RJB_WINDOW; i++)
            if (held_valid[i] && (best < 0 || held_ext[i] < held_ext[best])) best = i;
          if (best < 0 || held_ext[best] != last_released + EXT_ONE) break;
          held_valid[best] = 1'b0;
          push_release(held_tag[best], held_ext[best], ST_RELEASED);
        end
      end else if (ext > last_released) begin
        s = -1;
        for (int i = 0; i < RJB_WINDOW; i++)
          if (s < 0 && held_valid[i] && held_ext[i] == ext) s = i;
        for (int i = 0; i < RJB_WINDOW; i++)
          if (s < 0 && !held_valid[i]) s = i;
        if (s < 0) begin
          // A drop does not move the release point.
          keep_release = last_released;
          push_release(tag, ext, ST_DROPPED);
          last_released = keep_release;
        end else begin
          held_valid[s] = 1'b1; held_tag[s] = tag; held_ext[s] = ext; held_time[s] = now;
        end
        timeout_sweep(now);
      end
    end
    if (step_out.size() > 0) step_out[$].last = 1'b1;
    foreach (step_out[k]) expected_releases.push_back(step_out[k]);
  endfunction

  always @(posedge clk) begin
    release_t e;
    if (!rst_n) begin
      timeout_ms <= 32'(DEF_TIMEOUT); report_int <= 32'(DEF_REPORT_INT);
      drop_limit <= 32'(DEF_MAX_DROPOUT); misorder_limit <= 32'(DEF_MAX_MISORD);
      started = 1'b0; highest_seq = '0; suspect_seq = NO_SEQ; wrap_offset = '0;
      last_released = '0; last_report = '0; fail_count <= 0;
      for (int i = 0; i < RJB_WINDOW; i++) held_valid[i] = 1'b0;
      expected_releases.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready)
        case (cfg_if.index)
          REG_TIMEOUT:     timeout_ms     <= 32'(cfg_if.data);
          REG_REPORT_INT:  report_int     <= 32'(cfg_if.data);
          REG_MAX_DROPOUT: drop_limit     <= 32'(cfg_if.data);
          REG_MAX_MISORD:  misorder_limit <= 32'(cfg_if.data);
          default: ;
        endcase
      if (in_if.valid && in_if.ready)
        predict_item(in_if.operation, in_if.seq_num, in_if.packet_tag, in_if.now_ms);
      if (out_if.valid && out_if.ready) begin
        if (expected_releases.size() == 0) begin
          $error("unexpected result item: tag %h ext %h", out_if.out_tag, out_if.out_ext_seq);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_releases.pop_front();
          if (out_if.out_tag !== e.tag || out_if.out_ext_seq !== e.ext ||
              out_if.status !== e.status || out_if.last !== e.last) begin
            if (out_if.out_tag !== e.tag)
              $error("out_tag: expected %h, actual %h", e.tag, out_if.out_tag);
            if (out_if.out_ext_seq !== e.ext)
              $error("out_ext_seq: expected %h, actual %h", e.ext, out_if.out_ext_seq);
            if (out_if.status !== e.status)
              $error("status: expected %0d, actual %0d", e.status, out_if.status);
            if (out_if.last !== e.last)
              $error("last: expected %0b, actual %0b", e.last, out_if.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_releases.size();
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Top of the jitter buffer testbench: clock, reset, stimulus, register phases and verdict.
module testbench;
  import rjb_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  logic hold_off;   // Set by the stimulus to ask the receiver for a long stall.

  rjb_in_if  in_if ();
  rjb_out_if out_if ();
  rjb_cfg_if cfg_if ();

  rtp_reorder_jitter_buffer u_dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  rjb_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if),
    .fail_count(fail_count), .pending(pending)
  );

  // Stream state kept by the stimulus so that most packets form a plausible,
  // mostly increasing sequence with some reordering, holes and jumps.
  logic [15:0] next_seq;
  logic [31:0] clock_ms;
  int          gap_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // The receiver stalls on its own pseudo-random pattern. When a long hold-off
  // is requested it keeps ready low for a counted number of cycles.
  initial begin
    int stall_run;
    out_if.ready = 1'b0;
    stall_run = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_if.ready <= 1'b0;
        for (int c = 0; c < 600; c++) @(negedge clk);
        hold_off = 1'b0;
      end
      if (stall_run > 0) begin
        stall_run--;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_run = $urandom_range(1, 8);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Offers one item and holds it until it is accepted. Between items the
  // sender runs in bursts with random gaps.
  task automatic send_item(input logic op, input logic [15:0] seq, input logic [15:0] tag,
                           input logic [31:0] now);
    in_if.valid      <= 1'b1;
    in_if.operation  <= op;
    in_if.seq_num    <= seq;
    in_if.packet_tag <= tag;
    in_if.now_ms     <= now;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    if (gap_left > 0) begin
      gap_left--;
    end else begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      gap_left = $urandom_range(0, 8);
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // Items that cause no result may still be in flight: allow a full scan.
    repeat (1200) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic packet_item(input logic [15:0] seq);
    clock_ms = clock_ms + $urandom_range(0, 40);
    send_item(OP_PACKET, seq, 16'($urandom), clock_ms);
  endtask

  task automatic tick_item();
    clock_ms = clock_ms + $urandom_range(0, 150);
    send_item(OP_TICK, 16'($urandom), 16'($urandom), clock_ms);
  endtask

  // Random mix of the stream: next-in-line packets most often, some early packets,
  // duplicates, late packets, jump pairs and pure noise.
  task automatic random_item();
    int pick;
    logic [15:0] s;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      packet_item(next_seq);
      next_seq++;
    end else if (pick < 60) begin
      packet_item(next_seq + 16'($urandom_range(1, 12)));
    end else if (pick < 68) begin
      packet_item(next_seq - 16'($urandom_range(1, 20)));
    end else if (pick < 72) begin
      s = 16'($urandom);
      packet_item(s);
      packet_item(s + 16'd1);
      next_seq = s + 16'd2;
    end else if (pick < 88) begin
      tick_item();
    end else if (pick < 94) begin
      clock_ms = clock_ms + $urandom;
      send_item(OP_PACKET, 16'($urandom), 16'($urandom), clock_ms);
    end else begin
      send_item(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 32'($urandom));
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.operation = OP_PACKET;
    in_if.seq_num = '0;
    in_if.packet_tag = '0;
    in_if.now_ms = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    hold_off = 1'b0;
    gap_left = 0;
    clock_ms = 32'd1000;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at reset settings: first packet, in-order, early packets
    // that drain, a duplicate, an old packet, a wrap, a jump pair and ticks
    // with past and extreme times.
    packet_item(16'hFFFE);
    packet_item(16'hFFFF);
    packet_item(16'h0002);
    packet_item(16'h0002);
    packet_item(16'h0001);
    packet_item(16'h0000);
    packet_item(16'hFFF0);
    packet_item(16'h0005);
    tick_item();
    send_item(OP_TICK, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(OP_TICK, 16'h0000, 16'h0000, 32'h0000_0000);
    packet_item(16'h8000);
    packet_item(16'h8001);
    packet_item(16'h8002);
    next_seq = 16'h8003;
    wait_drained();

    // Small limits: everything is a jump or old, reports due whenever time moves on, fast timeout.
    write_reg(REG_TIMEOUT, 16'd0);
    write_reg(REG_REPORT_INT, 16'd0);
    write_reg(REG_MAX_DROPOUT, 16'd1);
    write_reg(REG_MAX_MISORD, 16'd1);
    write_reg(8'hFF, 16'hFFFF);
    for (int i = 0; i < 20; i++) random_item();
    wait_drained();

    // Large limits: a long timeout lets the store fill, and the receiver
    // stalls for a long stretch while the sender keeps offering.
    write_reg(REG_TIMEOUT, 16'hFFFF);
    write_reg(REG_REPORT_INT, 16'hFFFF);
    write_reg(REG_MAX_DROPOUT, 16'hFFFF);
    write_reg(REG_MAX_MISORD, 16'hFFFF);
    packet_item(next_seq);
    hold_off = 1'b1;
    for (int i = 0; i < 36; i++) packet_item(next_seq + 16'(2 + i));
    wait_drained();
    write_reg(REG_TIMEOUT, 16'd0);
    tick_item();
    wait_drained();

    // Back to moderate settings for the bulk of the random part.
    write_reg(REG_TIMEOUT, 16'd100);
    write_reg(REG_REPORT_INT, 16'd200);
    write_reg(REG_MAX_DROPOUT, 16'd3000);
    write_reg(REG_MAX_MISORD, 16'd100);
    for (int i = 0; i < 40; i++) random_item();
    wait_drained();

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
